FILE: rtl/tfe_pkg.sv
// Package for the texel format expander: format codes, sizes and widening functions.
package tfe_pkg;

   localparam int unsigned PAL_DEPTH = 256;
   localparam int unsigned PAL_WIDTH = 24;
   localparam int unsigned PAL_ADDR_W = 8;

   localparam logic [3:0] FMT_RGB332   = 4'd0;
   localparam logic [3:0] FMT_A8       = 4'd1;
   localparam logic [3:0] FMT_I8       = 4'd2;
   localparam logic [3:0] FMT_AI44     = 4'd3;
   localparam logic [3:0] FMT_P8       = 4'd4;
   localparam logic [3:0] FMT_ARGB8332 = 4'd5;
   localparam logic [3:0] FMT_RGB565   = 4'd6;
   localparam logic [3:0] FMT_ARGB1555 = 4'd7;
   localparam logic [3:0] FMT_ARGB4444 = 4'd8;
   localparam logic [3:0] FMT_AI88     = 4'd9;
   localparam logic [3:0] FMT_AP88     = 4'd10;
   localparam logic [3:0] FMT_ARGB8888 = 4'd11;
   localparam logic [3:0] FMT_RGB888   = 4'd12;

   localparam logic CMD_CONVERT   = 1'b0;
   localparam logic CMD_PAL_WRITE = 1'b1;

   localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;

   // widen a narrow channel to 8 bits by repeating it from the top
   function automatic logic [7:0] widen1(input logic v);
      widen1 = {8{v}};
   endfunction

   function automatic logic [7:0] widen2(input logic [1:0] v);
      widen2 = {v, v, v, v};
   endfunction

   function automatic logic [7:0] widen3(input logic [2:0] v);
      widen3 = {v, v, v[2:1]};
   endfunction

   function automatic logic [7:0] widen4(input logic [3:0] v);
      widen4 = {v, v};
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] v);
      widen5 = {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      widen6 = {v, v[5:4]};
   endfunction

   function automatic logic fmt_valid(input logic [3:0] f);
      fmt_valid = (f <= FMT_RGB888);
   endfunction

endpackage

FILE: rtl/tfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfe_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tfe_expand.sv
// Format decode: widens one texel (or palette color) to ARGB8888.
module tfe_expand import tfe_pkg::*; (
   input  logic [3:0]           pixel_format,
   input  logic [31:0]          texel_word,
   input  logic [PAL_WIDTH-1:0] pal_color,
   output logic [31:0]          argb_out
);

   logic [7:0] b8;
   logic [7:0] h8;

   assign b8 = texel_word[7:0];
   assign h8 = texel_word[15:8];

   always_comb begin
      case (pixel_format)
         FMT_RGB332: begin
            argb_out = {8'hFF, widen3(b8[7:5]), widen3(b8[4:2]), widen2(b8[1:0])};
         end
         FMT_A8: begin
            argb_out = {b8, 24'hFF_FFFF};
         end
         FMT_I8: begin
            argb_out = {8'hFF, b8, b8, b8};
         end
         FMT_AI44: begin
            argb_out = {widen4(b8[7:4]), widen4(b8[3:0]), widen4(b8[3:0]),
                        widen4(b8[3:0])};
         end
         FMT_P8: begin
            argb_out = {8'hFF, pal_color};
         end
         FMT_ARGB8332: begin
            argb_out = {h8, widen3(b8[7:5]), widen3(b8[4:2]), widen2(b8[1:0])};
         end
         FMT_RGB565: begin
            argb_out = {8'hFF, widen5(texel_word[15:11]), widen6(texel_word[10:5]),
                        widen5(texel_word[4:0])};
         end
         FMT_ARGB1555: begin
            argb_out = {widen1(texel_word[15]), widen5(texel_word[14:10]),
                        widen5(texel_word[9:5]), widen5(texel_word[4:0])};
         end
         FMT_ARGB4444: begin
            argb_out = {widen4(texel_word[15:12]), widen4(texel_word[11:8]),
                        widen4(texel_word[7:4]), widen4(texel_word[3:0])};
         end
         FMT_AI88: begin
            argb_out = {h8, b8, b8, b8};
         end
         FMT_AP88: begin
            argb_out = {h8, pal_color};
         end
         FMT_ARGB8888: begin
            argb_out = texel_word;
         end
         FMT_RGB888: begin
            argb_out = {8'hFF, texel_word[23:0]};
         end
         default: begin
            argb_out = '0;
         end
      endcase
   end

endmodule

FILE: rtl/texel_format_expander.sv
// Top level of the texel format expander: CSR, palette RAM and three-stage pipeline.
//
//   channel  | dir | handshake           | contents
//   req      | in  | req_tvalid/tready   | tuser: cmd; tdata: texel, pal index, pal color
//   rsp      | out | rsp_tvalid/tready   | tdata: ARGB8888 texel
//   csr      | in  | APB, pready high    | reg 0 at 0x0: pixel_format
//
// One request per cycle sustained unless rsp_tready stalls; a conversion raises rsp_tvalid after
// the palette RAM read, format expansion and output register stages.
// Palette writes and conversions of an unused format produce no response.
// Each stage moves when its successor is empty or moving, so bubbles close up
// and a stalled response still lets earlier stages fill.
// Reset clears the valid bits and pixel_format; the palette is not cleared.
module texel_format_expander import tfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] cmd
   input  logic [63:0] req_tdata,   // [31:0] texel_word, [39:32] pal_index, [63:40] pal_color
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] argb_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0] format_ff, format_in;
   logic       csr_wr;

   logic       req_accept;
   logic       req_cmd;
   logic [31:0] req_texel;
   logic [PAL_ADDR_W-1:0] req_pal_index;
   logic [PAL_WIDTH-1:0]  req_pal_color;

   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  s1_format_ff;
   logic [31:0] s1_texel_ff;
   logic        s1_ready;
   logic [PAL_WIDTH-1:0] s1_pal;

   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] s2_argb_ff, s2_argb_in;
   logic        s2_ready;

   logic        s3_valid_ff, s3_valid_in;
   logic [31:0] s3_argb_ff;
   logic        s3_ready;

   logic        ram_wr_en;
   logic        ram_rd_en;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign format_in = (csr_wr && csr_paddr[2] == REG_PIXEL_FORMAT[0]) ?
                      csr_pwdata[3:0] : format_ff;
   assign csr_prdata = (csr_paddr[2] == REG_PIXEL_FORMAT[0]) ? {28'd0, format_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RGB332;
      end else begin
         format_ff <= format_in;
      end
   end

   // request fields
   assign req_cmd       = req_tuser;
   assign req_texel     = req_tdata[31:0];
   assign req_pal_index = req_tdata[39:32];
   assign req_pal_color = req_tdata[63:40];

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_accept = req_tvalid && req_tready;

   assign ram_wr_en = req_accept && req_cmd == CMD_PAL_WRITE;
   assign ram_rd_en = req_accept && req_cmd == CMD_CONVERT;

   tfe_ram #(
      .WIDTH (PAL_WIDTH),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_pal_index),
      .wr_data (req_pal_color),
      .rd_en   (ram_rd_en),
      .rd_addr (req_texel[PAL_ADDR_W-1:0]),
      .rd_data (s1_pal)
   );

   // stage 1: palette read in flight; drop writes and unused formats
   assign s1_valid_in = s1_ready ? (ram_rd_en && fmt_valid(format_ff)) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         s1_format_ff <= format_ff;
         s1_texel_ff  <= req_texel;
      end
   end

   // stage 2: expansion
   tfe_expand u_expand (
      .pixel_format (s1_format_ff),
      .texel_word   (s1_texel_ff),
      .pal_color    (s1_pal),
      .argb_out     (s2_argb_in)
   );

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_argb_ff <= s2_argb_in;
      end
   end

   // stage 3: output register
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_argb_ff <= s2_argb_ff;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_argb_ff;

`ifndef NO_ASSERTIONS
   // a held stage 1 item must keep its palette data
   a_pal_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |-> !ram_rd_en)
      else $error("palette read while stage 1 is stalled");

   // a palette write never produces a response slot
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en) |=> !s1_valid_ff)
      else $error("palette write entered the pipeline");

   // a conversion of a known format always enters stage 1
   a_conv_enters: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && fmt_valid(format_ff)) |=> s1_valid_ff)
      else $error("conversion lost at stage 1");

   // stage 2 keeps its item while the output is blocked
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s3_valid_ff && !rsp_tready) |=> (s2_valid_ff && $stable(s2_argb_ff)))
      else $error("stage 2 item lost during stall");
`endif

endmodule

FILE: verif/tb.sv
// Testbench for texel_format_expander: directed table, then randomized texel and palette traffic.
`timescale 1ns / 100ps

module tb;
   import tfe_pkg::*;

   localparam logic [3:0] FMT_UNUSED_LO = 4'd13;
   localparam logic [3:0] FMT_UNUSED_HI = 4'd15;
   localparam logic [2:0] PIXEL_FORMAT_ADDR = REG_PIXEL_FORMAT << 2;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_ROWS = 27;
   localparam int NUM_PHASES = 4;
   localparam int SEGMENTS = 5;
   localparam int SEGMENT_ITEMS = 60;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_LITERAL,
      CHECK_SILENT
   } check_kind_type;

   typedef struct packed {
      logic [3:0]     fmt;
      logic           cmd;
      logic [31:0]    texel;
      logic [7:0]     idx;
      logic [23:0]    color;
      check_kind_type kind;
      logic [31:0]    argb;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = CMD_CONVERT;  // [0] cmd
   logic [63:0] req_tdata = '0;           // [31:0] texel_word, [39:32] pal_index, [63:40] pal_color
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;                // [31:0] argb_out
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [3:0]  format_shadow = FMT_RGB332;
   logic [23:0] palette_shadow [PAL_DEPTH];
   bit          pal_written [PAL_DEPTH];
   logic [7:0]  written_entries [$];
   logic [31:0] argb_expected [$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          sender_idle_by_phase [NUM_PHASES] = '{0, 45, 0, 10};
   int          receiver_stall_by_phase [NUM_PHASES] = '{0, 0, 45, 10};

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{FMT_RGB332,    CMD_CONVERT,   32'h0000_00FF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFFFF_FFFF},
      '{FMT_RGB332,    CMD_CONVERT,   32'hFFFF_FF00, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFF00_0000},
      '{FMT_RGB332,    CMD_CONVERT,   32'h0000_006D, 8'h00, 24'h000000, CHECK_PREDICTED, '0},
      '{FMT_A8,        CMD_CONVERT,   32'h0000_0000, 8'h00, 24'h000000, CHECK_LITERAL,
        32'h00FF_FFFF},
      '{FMT_A8,        CMD_CONVERT,   32'h0000_00FF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFFFF_FFFF},
      '{FMT_I8,        CMD_CONVERT,   32'h0000_005A, 8'h00, 24'h000000, CHECK_PREDICTED, '0},
      '{FMT_AI44,      CMD_CONVERT,   32'h0000_00F0, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFF00_0000},
      '{FMT_AI44,      CMD_CONVERT,   32'h0000_000F, 8'h00, 24'h000000, CHECK_LITERAL,
        32'h00FF_FFFF},
      '{FMT_AI44,      CMD_PAL_WRITE, 32'h0000_0000, 8'h00, 24'h123456, CHECK_SILENT, '0},
      '{FMT_AI44,      CMD_PAL_WRITE, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF, CHECK_SILENT, '0},
      '{FMT_P8,        CMD_CONVERT,   32'h0000_0000, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFF12_3456},
      '{FMT_P8,        CMD_CONVERT,   32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF, CHECK_LITERAL,
        32'hFFFF_FFFF},
      '{FMT_ARGB8332,  CMD_CONVERT,   32'h0000_AB00, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hAB00_0000},
      '{FMT_ARGB8332,  CMD_CONVERT,   32'h0000_12B6, 8'h00, 24'h000000, CHECK_PREDICTED, '0},
      '{FMT_RGB565,    CMD_CONVERT,   32'h0000_FFFF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFFFF_FFFF},
      '{FMT_RGB565,    CMD_CONVERT,   32'hFFFF_0000, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFF00_0000},
      '{FMT_ARGB1555,  CMD_CONVERT,   32'h0000_8000, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFF00_0000},
      '{FMT_ARGB1555,  CMD_CONVERT,   32'h0000_7FFF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'h00FF_FFFF},
      '{FMT_ARGB4444,  CMD_CONVERT,   32'h0000_1234, 8'h00, 24'h000000, CHECK_LITERAL,
        32'h1122_3344},
      '{FMT_AI88,      CMD_CONVERT,   32'h0000_80FF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'h80FF_FFFF},
      '{FMT_AP88,      CMD_CONVERT,   32'h0000_0100, 8'h00, 24'h000000, CHECK_LITERAL,
        32'h0112_3456},
      '{FMT_AP88,      CMD_CONVERT,   32'h0000_FFFF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFFFF_FFFF},
      '{FMT_ARGB8888,  CMD_CONVERT,   32'hDEAD_BEEF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hDEAD_BEEF},
      '{FMT_RGB888,    CMD_CONVERT,   32'hFF00_0000, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFF00_0000},
      '{FMT_RGB888,    CMD_CONVERT,   32'h00AB_CDEF, 8'h00, 24'h000000, CHECK_LITERAL,
        32'hFFAB_CDEF},
      '{FMT_UNUSED_LO, CMD_CONVERT,   32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF, CHECK_SILENT, '0},
      '{FMT_UNUSED_HI, CMD_CONVERT,   32'h0000_0000, 8'h00, 24'h000000, CHECK_SILENT, '0}
   };

   texel_format_expander dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic flag_error(input string text);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, text);
      end
   endtask

   // repeat the low n bits from the top until a byte is full
   function automatic logic [7:0] replicate_to_byte(input logic [7:0] v, input int unsigned n);
      logic [15:0] acc;
      logic [7:0] field;
      int unsigned filled;
      field = v & ((8'd1 << n) - 8'd1);
      acc = '0;
      filled = 0;
      while (filled < 8) begin
         acc = (acc << n) | 16'(field);
         filled += n;
      end
      return 8'(acc >> (filled - 8));
   endfunction

   function automatic bit expand_texel(input logic [3:0] fmt, input logic [31:0] t,
                                       output logic [31:0] argb);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] lum;
      lo = t[7:0];
      hi = t[15:8];
      argb = '0;
      case (fmt)
         FMT_RGB332: begin
            argb = {8'hFF, replicate_to_byte(lo >> 5, 3), replicate_to_byte(lo >> 2, 3),
                    replicate_to_byte(lo, 2)};
         end
         FMT_A8: argb = {lo, 24'hFFFFFF};
         FMT_I8: argb = {8'hFF, lo, lo, lo};
         FMT_AI44: begin
            lum = replicate_to_byte(lo, 4);
            argb = {replicate_to_byte(lo >> 4, 4), lum, lum, lum};
         end
         FMT_P8: argb = {8'hFF, palette_shadow[lo]};
         FMT_ARGB8332: begin
            argb = {hi, replicate_to_byte(lo >> 5, 3), replicate_to_byte(lo >> 2, 3),
                    replicate_to_byte(lo, 2)};
         end
         FMT_RGB565: begin
            argb = {8'hFF, replicate_to_byte(8'(t[15:11]), 5), replicate_to_byte(8'(t[10:5]), 6),
                    replicate_to_byte(8'(t[4:0]), 5)};
         end
         FMT_ARGB1555: begin
            argb = {replicate_to_byte(8'(t[15]), 1), replicate_to_byte(8'(t[14:10]), 5),
                    replicate_to_byte(8'(t[9:5]), 5), replicate_to_byte(8'(t[4:0]), 5)};
         end
         FMT_ARGB4444: begin
            argb = {replicate_to_byte(8'(t[15:12]), 4), replicate_to_byte(8'(t[11:8]), 4),
                    replicate_to_byte(8'(t[7:4]), 4), replicate_to_byte(8'(t[3:0]), 4)};
         end
         FMT_AI88: argb = {hi, lo, lo, lo};
         FMT_AP88: argb = {hi, palette_shadow[lo]};
         FMT_ARGB8888: argb = t;
         FMT_RGB888: argb = {8'hFF, t[23:0]};
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // result side: random stalls, compare each accepted texel with the oldest prediction
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (argb_expected.size() == 0) begin
            flag_error($sformatf("unexpected argb_out %08h", rsp_tdata));
         end else begin
            want = argb_expected.pop_front();
            if (rsp_tdata !== want) begin
               flag_error($sformatf("argb_out expected %08h actual %08h", want, rsp_tdata));
            end
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [31:0] texel, input logic [7:0] idx,
                               input logic [23:0] color, input check_kind_type kind,
                               input logic [31:0] literal_argb);
      logic [31:0] predicted;
      bit produces;
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {color, idx, texel};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_PAL_WRITE) begin
         palette_shadow[idx] = color;
         if (!pal_written[idx]) begin
            pal_written[idx] = 1'b1;
            written_entries.push_back(idx);
         end
      end else begin
         produces = expand_texel(format_shadow, texel, predicted);
         case (kind)
            CHECK_PREDICTED: if (produces) argb_expected.push_back(predicted);
            CHECK_LITERAL: argb_expected.push_back(literal_argb);
            default: ;
         endcase
      end
   endtask

   // hold the request side until every pending texel has come back
   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (argb_expected.size() != 0) @(posedge clock);
   endtask

   task automatic set_pixel_format(input logic [3:0] fmt);
      drain_requests();
      // let silent requests leave the pipeline too
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= PIXEL_FORMAT_ADDR;
      csr_pwdata <= 32'(fmt);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      format_shadow = fmt;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(fmt)) begin
         flag_error($sformatf("pixel_format read expected %08h actual %08h", 32'(fmt),
                              csr_prdata));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_random_request();
      logic [31:0] texel;
      logic [7:0] idx;
      logic [23:0] color;
      int unsigned roll;
      bit paletted;
      roll = $urandom_range(99);
      paletted = (format_shadow == FMT_P8) || (format_shadow == FMT_AP88);
      texel = $urandom();
      idx = 8'($urandom());
      color = 24'($urandom());
      if (roll < 10) begin
         texel = '0;
      end else if (roll < 20) begin
         texel = '1;
      end
      if ((paletted && (written_entries.size() == 0 || roll >= 80)) ||
          (!paletted && roll >= 90)) begin
         send_request(CMD_PAL_WRITE, texel, idx, color, CHECK_PREDICTED, '0);
      end else begin
         // never look up a palette entry that has not been written
         if (paletted) texel[7:0] = written_entries[$urandom_range(written_entries.size() - 1)];
         send_request(CMD_CONVERT, texel, idx, color, CHECK_PREDICTED, '0);
      end
   endtask

   initial begin
      logic [3:0] fmt_pick;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < NUM_ROWS; row++) begin
         if (directed_rows[row].fmt != format_shadow) set_pixel_format(directed_rows[row].fmt);
         send_request(directed_rows[row].cmd, directed_rows[row].texel, directed_rows[row].idx,
                      directed_rows[row].color, directed_rows[row].kind,
                      directed_rows[row].argb);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         sender_idle_pct = sender_idle_by_phase[phase];
         receiver_stall_pct = receiver_stall_by_phase[phase];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            if ($urandom_range(99) < 6) begin
               fmt_pick = 4'($urandom_range(FMT_UNUSED_HI, FMT_UNUSED_LO));
            end else begin
               fmt_pick = 4'($urandom_range(FMT_RGB888, FMT_RGB332));
            end
            set_pixel_format(fmt_pick);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
               if (seg == 2 && n == SEGMENT_ITEMS / 2) drain_requests();
               send_random_request();
            end
         end
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
